// ===== hw/rtl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants of the positional array list unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

   localparam int KEY_W   = 64;
   localparam int PAY_W   = 32;
   localparam int ENTRY_W = KEY_W + PAY_W;
   localparam int FUNC_W  = 3;
   localparam int POS_W   = 6;
   localparam int FPOS_W  = 5;
   localparam int COUNT_W = 6;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_FIND   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd5;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [POS_W-1:0]   position;
      logic [KEY_W-1:0]   entry_key;
      logic [PAY_W-1:0]   entry_payload;
   } pal_req_type;

   typedef struct packed {
      logic               ok;
      logic [FPOS_W-1:0]  found_position;
      logic [KEY_W-1:0]   read_key;
      logic [PAY_W-1:0]   read_payload;
      logic [COUNT_W-1:0] entry_count;
   } pal_rsp_type;

   typedef struct packed {
      logic idle;
      logic done;
   } pal_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pal_ram.sv =====
// ----------------------------------------------------------------------------
// pal_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 32
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire [WIDTH-1:0]           wr_data,
   input  wire                       rd_en,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// pal_ctrl
// Sequencer: walks the entry memory one read and one write-back at a time
// to shift, search, read and update entries, and keeps the entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_ctrl #(
   parameter int CAPACITY = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire pal_pkg::pal_req_type    req,
   input  wire                          res_take,
   output pal_pkg::pal_status_type      status,
   output pal_pkg::pal_rsp_type         res,
   output logic                         mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]  mem_wr_addr,
   output logic [pal_pkg::ENTRY_W-1:0]  mem_wr_data,
   output logic                         mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0]  mem_rd_addr,
   input  wire  [pal_pkg::ENTRY_W-1:0]  mem_rd_data
);

   localparam int IW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int XW   = CW + 1;
   localparam int CMPW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_RD   = 5'b00010,
      S_WR   = 5'b00100,
      S_PUT  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [pal_pkg::FUNC_W-1:0]  func_ff, func_in;
   logic [pal_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [pal_pkg::PAY_W-1:0]   pay_ff, pay_in;
   logic [IW-1:0]               pos_ff, pos_in;
   logic [IW-1:0]               idx_ff, idx_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic                        ok_ff, ok_in;
   logic [pal_pkg::FPOS_W-1:0]  fpos_ff, fpos_in;
   logic [pal_pkg::KEY_W-1:0]   rkey_ff, rkey_in;
   logic [pal_pkg::PAY_W-1:0]   rpay_ff, rpay_in;

   logic [CMPW-1:0]             pos_ext;
   logic [CMPW-1:0]             cnt_ext;
   logic [IW-1:0]               pos_idx;
   logic [pal_pkg::KEY_W-1:0]   rd_key;
   logic [pal_pkg::PAY_W-1:0]   rd_pay;

   assign pos_ext = CMPW'(req.position);
   assign cnt_ext = CMPW'(cnt_ff);
   assign pos_idx = IW'(req.position);
   assign rd_key  = mem_rd_data[pal_pkg::ENTRY_W-1:pal_pkg::PAY_W];
   assign rd_pay  = mem_rd_data[pal_pkg::PAY_W-1:0];

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      key_in      = key_ff;
      pay_in      = pay_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      ok_in       = ok_ff;
      fpos_in     = fpos_ff;
      rkey_in     = rkey_ff;
      rpay_in     = rpay_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in  = req.func;
               key_in   = req.entry_key;
               pay_in   = req.entry_payload;
               pos_in   = pos_idx;
               ok_in    = 1'b0;
               fpos_in  = '0;
               rkey_in  = '0;
               rpay_in  = '0;
               state_in = S_DONE;
               case (req.func)
                  pal_pkg::FUNC_INSERT: begin
                     if (cnt_ext < CMPW'(CAPACITY) && pos_ext <= cnt_ext) begin
                        idx_in   = IW'(cnt_ff);
                        state_in = (pos_ext == cnt_ext) ? S_PUT : S_RD;
                     end
                  end
                  pal_pkg::FUNC_DELETE: begin
                     if (pos_ext < cnt_ext) begin
                        idx_in = pos_idx;
                        if (XW'(pos_idx) + XW'(1) < XW'(cnt_ff)) begin
                           state_in = S_RD;
                        end else begin
                           cnt_in = cnt_ff - CW'(1);
                           ok_in  = 1'b1;
                        end
                     end
                  end
                  pal_pkg::FUNC_READ: begin
                     if (pos_ext < cnt_ext) begin
                        idx_in   = pos_idx;
                        state_in = S_RD;
                     end
                  end
                  pal_pkg::FUNC_UPDATE: begin
                     if (pos_ext < cnt_ext) begin
                        idx_in   = pos_idx;
                        state_in = S_PUT;
                     end
                  end
                  pal_pkg::FUNC_FIND: begin
                     idx_in = '0;
                     if (cnt_ff != '0) begin
                        state_in = S_RD;
                     end
                  end
                  pal_pkg::FUNC_CLEAR: begin
                     cnt_in = '0;
                     ok_in  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_RD: begin
            mem_rd_en = 1'b1;
            case (func_ff)
               pal_pkg::FUNC_INSERT: mem_rd_addr = idx_ff - IW'(1);
               pal_pkg::FUNC_DELETE: mem_rd_addr = idx_ff + IW'(1);
               default:              mem_rd_addr = idx_ff;
            endcase
            state_in = S_WR;
         end

         S_WR: begin
            case (func_ff)
               pal_pkg::FUNC_INSERT: begin
                  // move entry idx-1 up into idx
                  mem_wr_en = 1'b1;
                  idx_in    = idx_ff - IW'(1);
                  state_in  = (idx_ff - IW'(1) == pos_ff) ? S_PUT : S_RD;
               end
               pal_pkg::FUNC_DELETE: begin
                  // move entry idx+1 down into idx
                  mem_wr_en = 1'b1;
                  idx_in    = idx_ff + IW'(1);
                  if (XW'(idx_ff) + XW'(2) < XW'(cnt_ff)) begin
                     state_in = S_RD;
                  end else begin
                     cnt_in   = cnt_ff - CW'(1);
                     ok_in    = 1'b1;
                     state_in = S_DONE;
                  end
               end
               pal_pkg::FUNC_READ: begin
                  ok_in    = 1'b1;
                  rkey_in  = rd_key;
                  rpay_in  = rd_pay;
                  state_in = S_DONE;
               end
               pal_pkg::FUNC_FIND: begin
                  if (rd_key == key_ff) begin
                     ok_in    = 1'b1;
                     fpos_in  = pal_pkg::FPOS_W'(idx_ff);
                     rkey_in  = rd_key;
                     rpay_in  = rd_pay;
                     state_in = S_DONE;
                  end else if (CW'(idx_ff) + CW'(1) == cnt_ff) begin
                     state_in = S_DONE;
                  end else begin
                     idx_in   = idx_ff + IW'(1);
                     state_in = S_RD;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {key_ff, pay_ff};
            ok_in       = 1'b1;
            if (func_ff == pal_pkg::FUNC_INSERT) begin
               cnt_in = cnt_ff + CW'(1);
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            // hold the result until the output register takes it
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      func_ff <= func_in;
      key_ff  <= key_in;
      pay_ff  <= pay_in;
      pos_ff  <= pos_in;
      idx_ff  <= idx_in;
      ok_ff   <= ok_in;
      fpos_ff <= fpos_in;
      rkey_ff <= rkey_in;
      rpay_ff <= rpay_in;
   end

   assign status.idle        = (state_ff == S_IDLE);
   assign status.done        = (state_ff == S_DONE);
   assign res.ok             = ok_ff;
   assign res.found_position = fpos_ff;
   assign res.read_key       = rkey_ff;
   assign res.read_payload   = rpay_ff;
   assign res.entry_count    = pal_pkg::COUNT_W'(cnt_ff);

endmodule

`default_nettype wire

// ===== hw/rtl/positional_array_list_unit.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Bounded positional list of key/payload entries kept in one entry memory.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction (req_valid / req_stall) carries func, position,
//   entry_key and entry_payload. Each request produces exactly one response
//   transaction (rsp_valid / rsp_stall) with ok, found_position, read_key,
//   read_payload and the entry count after the operation.
//   One request is processed at a time; req_stall is high while the
//   sequencer is busy. Every touched entry takes one memory read and
//   one write-back or compare on the single entry memory:
//     clear, failed checks, delete of the last entry: no entry access
//     update: one write; read: one read
//     insert at p with count n: n-p entries moved up, then one write
//     delete at p with count n: n-p-1 entries moved down
//     find hitting position i: i+1 entries compared, a miss n
//   Reset empties the list at once; the memory is not cleared.
//   A stalled response waits in the output register while the next request
//   is already accepted and processed; that request's result is held in the
//   sequencer until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list_unit #(
   parameter int CAPACITY = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_func,
   input  wire  [5:0]  req_position,
   input  wire  [63:0] req_entry_key,
   input  wire  [31:0] req_entry_payload,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_ok,
   output logic [4:0]  rsp_found_position,
   output logic [63:0] rsp_read_key,
   output logic [31:0] rsp_read_payload,
   output logic [5:0]  rsp_entry_count
);

   localparam int IW = $clog2(CAPACITY);

   pal_pkg::pal_req_type     req;
   pal_pkg::pal_rsp_type     res;
   pal_pkg::pal_status_type  status;
   logic                     res_take;
   logic                     load;

   logic                        mem_wr_en;
   logic [IW-1:0]               mem_wr_addr;
   logic [pal_pkg::ENTRY_W-1:0] mem_wr_data;
   logic                        mem_rd_en;
   logic [IW-1:0]               mem_rd_addr;
   logic [pal_pkg::ENTRY_W-1:0] mem_rd_data;

   logic                  rsp_valid_ff, rsp_valid_in;
   pal_pkg::pal_rsp_type  rsp_ff, rsp_in;

   assign req.func          = req_func;
   assign req.position      = req_position;
   assign req.entry_key     = req_entry_key;
   assign req.entry_payload = req_entry_payload;

   assign req_stall = !status.idle;

   pal_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (req_valid),
      .req         (req),
      .res_take    (res_take),
      .status      (status),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   pal_ram #(
      .WIDTH (pal_pkg::ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register: free when empty or being drained this cycle
   assign res_take = !rsp_valid_ff || !rsp_stall;
   assign load     = status.done && res_take;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ff.ok;
   assign rsp_found_position = rsp_ff.found_position;
   assign rsp_read_key       = rsp_ff.read_key;
   assign rsp_read_payload   = rsp_ff.read_payload;
   assign rsp_entry_count    = rsp_ff.entry_count;

endmodule

`default_nettype wire
